// File: sv/spq_pkg.sv
package spq_pkg;

	localparam int unsigned CAPACITY_DEF      = 16;
	localparam int unsigned PRIORITY_BITS_DEF = 16;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned PRIO_W   = 16;
	localparam int unsigned COUNT_W  = 5;
	localparam int unsigned S_DATA_W = 48;
	localparam int unsigned M_DATA_W = 56;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_REMOVE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} cmd_t;

endpackage

// File: sv/spq_cell.sv
module spq_cell import spq_pkg::*; #(
	parameter int unsigned IDX = 0,
	parameter int unsigned PW  = PRIORITY_BITS_DEF,
	parameter int unsigned CW  = 5
) (
	input  logic               clk,
	input  cmd_t               cmd,
	input  logic [CW-1:0]      count,
	input  logic [VALUE_W-1:0] new_value,
	input  logic [PW-1:0]      new_prio,
	input  logic               prev_ge,
	input  logic [VALUE_W-1:0] left_value,
	input  logic [PW-1:0]      left_prio,
	input  logic [VALUE_W-1:0] right_value,
	input  logic [PW-1:0]      right_prio,
	output logic               ge,
	output logic [VALUE_W-1:0] value_q,
	output logic [PW-1:0]      prio_q
);

	logic occupied;

	assign occupied = CW'(IDX) < count;
	assign ge = occupied && ($signed(prio_q) >= $signed(new_prio));

	always_ff @(posedge clk) begin
		if (cmd.ins && !ge) begin
			if (prev_ge) begin
				value_q <= new_value;
				prio_q  <= new_prio;
			end else begin
				value_q <= left_value;
				prio_q  <= left_prio;
			end
		end else if (cmd.rem) begin
			value_q <= right_value;
			prio_q  <= right_prio;
		end
	end

endmodule

// File: sv/stable_priority_queue_unit.sv
// An accepted item's result is registered in the output register.
// Throughput: 1 item per cycle unless stalled; cells compare and shift at once.
// s_tready is high whenever the output register is empty or being taken.
// Reset (arst_n low, asynchronous) empties the queue and the output register;
// cell contents are not cleared and are read only below the held count.
module stable_priority_queue_unit import spq_pkg::*; #(
	parameter int unsigned CAPACITY      = CAPACITY_DEF,
	parameter int unsigned PRIORITY_BITS = PRIORITY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // item_value[31:0], item_priority[47:32]
	input  logic                s_tuser,  // action[0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // out_value[31:0], out_priority[47:32],
	                                      // entry_count[52:48], zero[55:53]
	output logic [1:0]          m_tuser   // status[1:0]
);

	localparam int unsigned PW = (PRIORITY_BITS < PRIO_W) ? PRIORITY_BITS : PRIO_W;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_next;
	logic               accept;
	logic               is_remove;
	logic               full;
	logic               empty;
	cmd_t               cmd;
	logic [VALUE_W-1:0] new_value;
	logic [PW-1:0]      new_prio;
	status_t            status;

	logic [VALUE_W-1:0] cell_value [CAPACITY];
	logic [PW-1:0]      cell_prio  [CAPACITY];
	logic               cell_ge    [CAPACITY];

	logic [VALUE_W-1:0] out_value_q;
	logic [PRIO_W-1:0]  out_prio_q;
	logic [COUNT_W-1:0] out_count_q;
	status_t            out_status_q;
	logic               out_valid_q;

	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign is_remove = (s_tuser == ACT_REMOVE);
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign new_value = s_tdata[VALUE_W-1:0];
	assign new_prio  = s_tdata[VALUE_W +: PW];

	assign cmd.ins = accept && !is_remove && !full;
	assign cmd.rem = accept && is_remove && !empty;

	always_comb begin
		count_next = count_q;
		if (cmd.ins)
			count_next = count_q + 1'b1;
		else if (cmd.rem)
			count_next = count_q - 1'b1;
	end

	always_comb begin
		if (is_remove)
			status = empty ? ST_EMPTY : ST_REMOVED;
		else
			status = full ? ST_FULL : ST_INSERTED;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic               prev_ge;
		logic [VALUE_W-1:0] left_value;
		logic [PW-1:0]      left_prio;
		logic [VALUE_W-1:0] right_value;
		logic [PW-1:0]      right_prio;

		if (i == 0) begin : g_first
			assign prev_ge    = 1'b1;
			assign left_value = new_value;
			assign left_prio  = new_prio;
		end else begin : g_mid
			assign prev_ge    = cell_ge[i-1];
			assign left_value = cell_value[i-1];
			assign left_prio  = cell_prio[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_value = cell_value[i];
			assign right_prio  = cell_prio[i];
		end else begin : g_inner
			assign right_value = cell_value[i+1];
			assign right_prio  = cell_prio[i+1];
		end

		spq_cell #(
			.IDX (i),
			.PW  (PW),
			.CW  (CW)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.count       (count_q),
			.new_value   (new_value),
			.new_prio    (new_prio),
			.prev_ge     (prev_ge),
			.left_value  (left_value),
			.left_prio   (left_prio),
			.right_value (right_value),
			.right_prio  (right_prio),
			.ge          (cell_ge[i]),
			.value_q     (cell_value[i]),
			.prio_q      (cell_prio[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q <= status;
			out_count_q  <= COUNT_W'(count_next);
			if (cmd.rem) begin
				out_value_q <= cell_value[0];
				out_prio_q  <= PRIO_W'($signed(cell_prio[0]));
			end else begin
				out_value_q <= '0;
				out_prio_q  <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {3'b000, out_count_q, out_prio_q, out_value_q};

endmodule

// File: sv/spq_checker.sv
module spq_checker import spq_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic [1:0]          m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[52:48] == '0 && m_tdata[47:0] == '0)
		else $error("empty status with nonzero fields");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_INSERTED || m_tuser == ST_FULL) |-> m_tdata[47:0] == '0)
		else $error("insert status with nonzero value or priority");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_FULL |-> m_tdata[52:48] == COUNT_W'(CAPACITY))
		else $error("full status with count below capacity");

endmodule

bind stable_priority_queue_unit spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);

// File: tb/stable_priority_queue_unit_tb.sv
`timescale 1ns / 1ps

module stable_priority_queue_unit_tb;
	import spq_pkg::*;

	localparam int unsigned CAP       = CAPACITY_DEF;
	localparam int unsigned PRIO_BITS = PRIORITY_BITS_DEF;
	localparam int N_RANDOM = 1830;
	localparam int N_ITEMS  = N_RANDOM + 23;

	typedef struct {
		action_t     act;
		logic [31:0] value;
		logic [15:0] prio;
		bit          drain;
	} pq_item_t;

	typedef struct {
		status_t     st;
		logic [31:0] value;
		logic [15:0] prio;
		logic [4:0]  count;
	} pq_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [1:0]          m_tuser;

	pq_item_t   items_to_send[$];
	pq_result_t results_due[$];
	pq_item_t   cur_item;
	int         sent_count = 0;
	int         mismatches = 0;
	int         hold_left = 0;
	int         holds_done = 0;

	// shadow copy of the sorted queue, front at index 0
	logic signed [31:0] shadow_value[CAP];
	logic signed [15:0] shadow_prio[CAP];
	int unsigned        shadow_count = 0;

	stable_priority_queue_unit #(
		.CAPACITY(CAP),
		.PRIORITY_BITS(PRIO_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic add_item(input action_t act, input logic [31:0] v, input logic [15:0] p,
			input bit drain);
		pq_item_t it;
		it.act   = act;
		it.value = v;
		it.prio  = p;
		it.drain = drain;
		items_to_send.push_back(it);
	endtask

	function automatic logic [15:0] rand_prio();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(4) - 2);
			2: begin
				case ($urandom_range(3))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					default: return 16'hFFFF;
				endcase
			end
			default: return 16'($urandom_range(16) - 8);
		endcase
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// receiver idle first, sender idle second, none last
	function automatic int idle_pct(input bit receiver);
		if (sent_count < N_ITEMS / 3)
			return receiver ? 66 : 14;
		else if (sent_count < 2 * N_ITEMS / 3)
			return receiver ? 14 : 66;
		return 0;
	endfunction

	task automatic apply_queue_op(input pq_item_t it);
		pq_result_t         r;
		logic signed [15:0] pe;
		int unsigned        pos;
		int unsigned        k;
		r.st    = ST_INSERTED;
		r.value = '0;
		r.prio  = '0;
		pe = $signed(it.prio << (PRIO_W - PRIO_BITS)) >>> (PRIO_W - PRIO_BITS);
		if (it.act == ACT_INSERT) begin
			if (shadow_count >= CAP) begin
				r.st = ST_FULL;
			end else begin
				pos = 0;
				while (pos < shadow_count && shadow_prio[pos] >= pe)
					pos++;
				for (k = shadow_count; k > pos; k--) begin
					shadow_value[k] = shadow_value[k - 1];
					shadow_prio[k]  = shadow_prio[k - 1];
				end
				shadow_value[pos] = it.value;
				shadow_prio[pos]  = pe;
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				r.st = ST_EMPTY;
			end else begin
				r.st    = ST_REMOVED;
				r.value = shadow_value[0];
				r.prio  = shadow_prio[0];
				for (k = 1; k < shadow_count; k++) begin
					shadow_value[k - 1] = shadow_value[k];
					shadow_prio[k - 1]  = shadow_prio[k];
				end
				shadow_count--;
			end
		end
		r.count = shadow_count[4:0];
		results_due.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < 40)
			$display("%0t: %s mismatch, got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_queue_op(cur_item);
				sent_count++;
			end
			if (!s_tvalid || s_tready) begin
				if (items_to_send.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)
						&& !(items_to_send[0].drain && results_due.size() != 0)) begin
					cur_item = items_to_send.pop_front();
					s_tdata  <= {cur_item.prio, cur_item.value};
					s_tuser  <= cur_item.act;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the output register fills and input stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left  <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_done < 2 && sent_count >= 400 + 900 * holds_done) begin
			hold_left  <= 90;
			holds_done <= holds_done + 1;
		end
	end

	// monitor
	always @(posedge clk) begin
		pq_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					report_mismatch("unexpected item", 64'(m_tdata), 64'(0));
				end else begin
					want = results_due.pop_front();
					if (m_tuser !== want.st)
						report_mismatch("status", 64'(m_tuser), 64'(want.st));
					if (m_tdata[31:0] !== want.value)
						report_mismatch("out_value", 64'(m_tdata[31:0]), 64'(want.value));
					if (m_tdata[47:32] !== want.prio)
						report_mismatch("out_priority", 64'(m_tdata[47:32]), 64'(want.prio));
					if (m_tdata[52:48] !== want.count)
						report_mismatch("entry_count", 64'(m_tdata[52:48]), 64'(want.count));
					if (m_tdata[55:53] !== 3'b000)
						report_mismatch("tdata pad", 64'(m_tdata[55:53]), 64'(0));
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
		end
	end

	initial begin
		int i;
		int ins_pct;
		action_t act;
		// remove from empty
		add_item(ACT_REMOVE, $urandom, 16'($urandom), 1'b0);
		// extremes and equal priorities, then fill to capacity
		add_item(ACT_INSERT, 32'h7FFF_FFFF, 16'h7FFF, 1'b0);
		add_item(ACT_INSERT, 32'h8000_0000, 16'h8000, 1'b0);
		add_item(ACT_INSERT, 32'h0000_0000, 16'h0000, 1'b0);
		add_item(ACT_INSERT, 32'hFFFF_FFFF, 16'h0000, 1'b0);
		add_item(ACT_INSERT, 32'h0000_0001, 16'h0000, 1'b0);
		add_item(ACT_INSERT, 32'h0000_0002, 16'hFFFF, 1'b0);
		add_item(ACT_INSERT, 32'h0000_0003, 16'h7FFF, 1'b0);
		add_item(ACT_INSERT, 32'h0000_0004, 16'h8000, 1'b0);
		for (i = 0; i < 8; i++)
			add_item(ACT_INSERT, $urandom, rand_prio(), 1'b0);
		// full: dropped even at top priority
		add_item(ACT_INSERT, 32'hFFFF_FFFF, 16'h7FFF, 1'b0);
		add_item(ACT_REMOVE, $urandom, 16'($urandom), 1'b0);
		add_item(ACT_REMOVE, $urandom, 16'($urandom), 1'b0);
		add_item(ACT_INSERT, 32'hAAAA_5555, 16'h5555, 1'b0);
		add_item(ACT_INSERT, 32'h5555_AAAA, 16'hAAAA, 1'b0);
		add_item(ACT_INSERT, 32'h0000_0000, 16'h8000, 1'b0);
		add_item(ACT_REMOVE, $urandom, 16'($urandom), 1'b0);

		ins_pct = 50;
		for (i = 0; i < N_RANDOM; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(4))
					0: ins_pct = 10;
					1: ins_pct = 30;
					2: ins_pct = 50;
					3: ins_pct = 70;
					default: ins_pct = 90;
				endcase
			end
			act = ($urandom_range(99) < ins_pct) ? ACT_INSERT : ACT_REMOVE;
			add_item(act, rand_value(), rand_prio(), i % 300 == 0);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (items_to_send.size() != 0 || s_tvalid)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#(2_000_000);
		$display("TEST FAILED");
		$finish;
	end

endmodule
